>>> hw/rtl/bps_pkg.sv
package bps_pkg;

	typedef logic signed [15:0] q14_t;
	typedef logic [13:0] coef_t;
	typedef logic [14:0] unit_t;

	typedef enum logic [1:0] {
		REG_EYE_X = 2'd0,
		REG_EYE_Y = 2'd1,
		REG_EYE_Z = 2'd2
	} reg_idx_t;

	localparam logic signed [19:0] EYE_X_RESET = 20'sd0;
	localparam logic signed [19:0] EYE_Y_RESET = 20'sd0;
	localparam logic signed [19:0] EYE_Z_RESET = 20'sd40960;

	localparam unit_t ONE_Q14 = 15'd16384;

	// light directions, unit vectors in Q1.14
	localparam q14_t LIGHT_DIR [3][3] = '{
		'{ 16'sd7639,  -16'sd4583,  16'sd13750},
		'{-16'sd10098,  16'sd11540, 16'sd5770},
		'{ 16'sd3153,  -16'sd15766, -16'sd3153}
	};

	localparam coef_t AMB [3] = '{14'd767, 14'd541, 14'd275};
	localparam coef_t KD [3][3] = '{
		'{14'd11502, 14'd7209, 14'd2982},
		'{14'd2556,  14'd2703, 14'd2523},
		'{14'd1534,  14'd901,  14'd367}
	};
	localparam coef_t KS [3][3] = '{
		'{14'd6636, 14'd5898, 14'd4792},
		'{14'd1475, 14'd2212, 14'd4055},
		'{14'd885,  14'd737,  14'd590}
	};
	localparam coef_t RIM [3] = '{14'd2294, 14'd2867, 14'd3727};

	// Q.14 product rounded half up; inputs never exceed 1.0
	function automatic unit_t mul14(input unit_t a, input unit_t b);
		logic [29:0] p;
		p = 30'(a) * 30'(b);
		return 15'((p + 30'd8192) >> 14);
	endfunction

endpackage

>>> hw/rtl/blinn_phong_three_light_shader.sv
// channel   dir  handshake              payload
// config    in   wr_en                  wr_index, wr_data (eye x/y/z, Q7.12)
// point     in   point_valid/point_stall point_x/y/z, normal_x/y/z
// color     out  color_valid/color_stall red, green, blue (Q2.12)
//
// One word enters per cycle unless stalled; depth is set by the two normalize
// units (32 and 28 root stages, 16 divide stages each) plus the power chain.
// Reset clears valid bits and sets the eye to (0, 0, 10.0).
// A stalled output word freezes the whole pipeline; point_stall follows it.
module blinn_phong_three_light_shader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [19:0] wr_data,
	input  logic        point_valid,
	output logic        point_stall,
	input  logic [19:0] point_x,
	input  logic [19:0] point_y,
	input  logic [19:0] point_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [15:0] normal_z,
	output logic        color_valid,
	input  logic        color_stall,
	output logic [13:0] red,
	output logic [13:0] green,
	output logic [13:0] blue
);

	logic signed [19:0] eye_x_q, eye_y_q, eye_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= bps_pkg::EYE_X_RESET;
			eye_y_q <= bps_pkg::EYE_Y_RESET;
			eye_z_q <= bps_pkg::EYE_Z_RESET;
		end else if (wr_en) begin
			case (bps_pkg::reg_idx_t'(wr_index))
				bps_pkg::REG_EYE_X: eye_x_q <= wr_data;
				bps_pkg::REG_EYE_Y: eye_y_q <= wr_data;
				bps_pkg::REG_EYE_Z: eye_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15;

	assign en          = !(v_s15 && color_stall);
	assign point_stall = !en;

	// s1: view difference
	logic [2:0][20:0] d_s1;
	logic [2:0][15:0] n_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 21'($signed(eye_x_q)) - 21'($signed(point_x));
			d_s1[1] <= 21'($signed(eye_y_q)) - 21'($signed(point_y));
			d_s1[2] <= 21'($signed(eye_z_q)) - 21'($signed(point_z));
			n_s1    <= {normal_z, normal_y, normal_x};
		end
	end

	logic             va;
	logic [2:0][15:0] v_a;
	logic [47:0]      n_a;

	bps_unit3 #(.CW(21), .SW(48)) u_view (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_c     (d_s1),
		.in_side  (n_s1),
		.out_valid(va),
		.out_u    (v_a),
		.out_side (n_a)
	);

	// s2: N.V and N.L products
	logic signed [31:0] pnv_s2 [3];
	logic signed [31:0] pnl_s2 [3][3];
	logic signed [15:0] n_s2 [3];
	logic signed [15:0] vv_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				n_s2[c]   <= n_a[16*c +: 16];
				vv_s2[c]  <= v_a[c];
				pnv_s2[c] <= 32'($signed(n_a[16*c +: 16])) * 32'($signed(v_a[c]));
				for (int i = 0; i < 3; i++) begin
					pnl_s2[i][c] <= 32'($signed(n_a[16*c +: 16])) *
						32'(bps_pkg::LIGHT_DIR[i][c]);
				end
			end
		end
	end

	// s3: flip the normal toward the eye, diffuse terms, Fresnel base,
	// unnormalized half vectors
	logic signed [33:0] ndv_c, ndv_abs;
	logic               flip_c;
	logic [19:0]        absv_c;
	logic [14:0]        f_c;
	logic [2:0][16:0]   nf_c;
	logic [2:0][17:0]   ndl_c;
	logic [2:0][16:0]   s_c [3];

	always_comb begin
		ndv_c   = 34'(pnv_s2[0]) + 34'(pnv_s2[1]) + 34'(pnv_s2[2]);
		flip_c  = ndv_c < 0;
		ndv_abs = flip_c ? -ndv_c : ndv_c;
		absv_c  = 20'((ndv_abs + 34'sd8192) >>> 14);
		f_c     = (absv_c >= 20'(bps_pkg::ONE_Q14)) ? '0 :
			15'(20'(bps_pkg::ONE_Q14) - absv_c);
		for (int c = 0; c < 3; c++) begin
			nf_c[c] = flip_c ? -17'(n_s2[c]) : 17'(n_s2[c]);
		end
		for (int i = 0; i < 3; i++) begin
			logic signed [33:0] dot, dflip;
			dot   = 34'(pnl_s2[i][0]) + 34'(pnl_s2[i][1]) + 34'(pnl_s2[i][2]);
			dflip = flip_c ? -dot : dot;
			ndl_c[i] = (dflip <= 0) ? '0 : 18'((dflip + 34'sd8192) >>> 14);
			for (int c = 0; c < 3; c++) begin
				s_c[i][c] = 17'(bps_pkg::LIGHT_DIR[i][c]) + 17'(vv_s2[c]);
			end
		end
	end

	logic [2:0][16:0] nf_s3;
	logic [2:0][17:0] ndl_s3;
	logic [14:0]      f_s3;
	logic [2:0][16:0] s_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			nf_s3  <= nf_c;
			ndl_s3 <= ndl_c;
			f_s3   <= f_c;
			s_s3   <= s_c;
		end
	end

	// half vectors, one unit per light; each carries part of the side data
	logic [2:0]        vh;
	logic [2:0][15:0]  h_b [3];
	logic [50:0]       nf_b;
	logic [53:0]       ndl_b;
	logic [14:0]       f_b;

	bps_unit3 #(.CW(17), .SW(51)) u_half0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_c     (s_s3[0]),
		.in_side  (nf_s3),
		.out_valid(vh[0]),
		.out_u    (h_b[0]),
		.out_side (nf_b)
	);

	bps_unit3 #(.CW(17), .SW(54)) u_half1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_c     (s_s3[1]),
		.in_side  (ndl_s3),
		.out_valid(vh[1]),
		.out_u    (h_b[1]),
		.out_side (ndl_b)
	);

	bps_unit3 #(.CW(17), .SW(15)) u_half2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_c     (s_s3[2]),
		.in_side  (f_s3),
		.out_valid(vh[2]),
		.out_u    (h_b[2]),
		.out_side (f_b)
	);

	// s4: N.H products
	logic signed [32:0] pnh_s4 [3][3];
	logic [2:0][17:0]   ndl_s4;
	logic [14:0]        f_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ndl_s4 <= ndl_b;
			f_s4   <= f_b;
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					pnh_s4[i][c] <= 33'($signed(nf_b[17*c +: 17])) *
						33'($signed(h_b[i][c]));
				end
			end
		end
	end

	// s5: N.H, clamped to [0, 1.0]
	logic [2:0][14:0] ndh_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [34:0] dot;
			logic [20:0]        r;
			dot = 35'(pnh_s4[i][0]) + 35'(pnh_s4[i][1]) + 35'(pnh_s4[i][2]);
			r   = 21'((dot + 35'sd8192) >>> 14);
			if (dot <= 0) begin
				ndh_c[i] = '0;
			end else if (r > 21'(bps_pkg::ONE_Q14)) begin
				ndh_c[i] = bps_pkg::ONE_Q14;
			end else begin
				ndh_c[i] = 15'(r);
			end
		end
	end

	logic [2:0][14:0] ndh_s5;
	logic [2:0][17:0] ndl_s5;
	logic [14:0]      f_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ndh_s5 <= ndh_c;
			ndl_s5 <= ndl_s4;
			f_s5   <= f_s4;
		end
	end

	// s6..s13: x^60 = x^32 * x^16 * x^8 * x^4, and f^3
	logic [2:0][14:0] x2_s6, x4_s7, x4_s8, x8_s8, x4_s9, x8_s9, x16_s9;
	logic [2:0][14:0] x4_s10, x8_s10, x16_s10, x32_s10;
	logic [2:0][14:0] x4_s11, x8_s11, p1_s11, x4_s12, p2_s12, spec_s13;
	logic [14:0]      f_s6, ff_s6, f3_s7, f3_s8, f3_s9, f3_s10, f3_s11, f3_s12, f3_s13;
	logic [2:0][17:0] ndl_s6, ndl_s7, ndl_s8, ndl_s9, ndl_s10, ndl_s11, ndl_s12, ndl_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s6    <= f_s5;
			ff_s6   <= bps_pkg::mul14(f_s5, f_s5);
			f3_s7   <= bps_pkg::mul14(ff_s6, f_s6);
			f3_s8   <= f3_s7;
			f3_s9   <= f3_s8;
			f3_s10  <= f3_s9;
			f3_s11  <= f3_s10;
			f3_s12  <= f3_s11;
			f3_s13  <= f3_s12;
			ndl_s6  <= ndl_s5;
			ndl_s7  <= ndl_s6;
			ndl_s8  <= ndl_s7;
			ndl_s9  <= ndl_s8;
			ndl_s10 <= ndl_s9;
			ndl_s11 <= ndl_s10;
			ndl_s12 <= ndl_s11;
			ndl_s13 <= ndl_s12;
			for (int i = 0; i < 3; i++) begin
				x2_s6[i]    <= bps_pkg::mul14(ndh_s5[i], ndh_s5[i]);
				x4_s7[i]    <= bps_pkg::mul14(x2_s6[i], x2_s6[i]);
				x8_s8[i]    <= bps_pkg::mul14(x4_s7[i], x4_s7[i]);
				x4_s8[i]    <= x4_s7[i];
				x16_s9[i]   <= bps_pkg::mul14(x8_s8[i], x8_s8[i]);
				x8_s9[i]    <= x8_s8[i];
				x4_s9[i]    <= x4_s8[i];
				x32_s10[i]  <= bps_pkg::mul14(x16_s9[i], x16_s9[i]);
				x16_s10[i]  <= x16_s9[i];
				x8_s10[i]   <= x8_s9[i];
				x4_s10[i]   <= x4_s9[i];
				p1_s11[i]   <= bps_pkg::mul14(x32_s10[i], x16_s10[i]);
				x8_s11[i]   <= x8_s10[i];
				x4_s11[i]   <= x4_s10[i];
				p2_s12[i]   <= bps_pkg::mul14(p1_s11[i], x8_s11[i]);
				x4_s12[i]   <= x4_s11[i];
				spec_s13[i] <= bps_pkg::mul14(p2_s12[i], x4_s12[i]);
			end
		end
	end

	// s14: weight each term per color
	logic [31:0] kdt_s14 [3][3];
	logic [28:0] kst_s14 [3][3];
	logic [28:0] rim_s14 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				rim_s14[c] <= 29'(bps_pkg::RIM[c]) * 29'(f3_s13);
				for (int i = 0; i < 3; i++) begin
					kdt_s14[i][c] <= 32'(bps_pkg::KD[i][c]) * 32'(ndl_s13[i]);
					kst_s14[i][c] <= 29'(bps_pkg::KS[i][c]) * 29'(spec_s13[i]);
				end
			end
		end
	end

	// s15: sum in Q.28, round to Q.12, saturate
	logic [2:0][13:0] col_c;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [35:0] acc;
			logic [19:0] o;
			acc = (36'(bps_pkg::AMB[c]) << 14) + 36'(rim_s14[c]);
			for (int i = 0; i < 3; i++) begin
				acc = acc + 36'(kdt_s14[i][c]) + 36'(kst_s14[i][c]);
			end
			o = 20'((acc + 36'd32768) >> 16);
			col_c[c] = (o > 20'd16383) ? 14'd16383 : 14'(o);
		end
	end

	logic [2:0][13:0] col_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s15 <= col_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1  <= point_valid;
			v_s2  <= va;
			v_s3  <= v_s2;
			v_s4  <= vh[0];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	assign color_valid = v_s15;
	assign red         = col_s15[0];
	assign green       = col_s15[1];
	assign blue        = col_s15[2];

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && color_stall |-> point_stall)
		else $error("input taken while output word is held");

	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!color_valid |-> !point_stall)
		else $error("input stalled with empty output");

	a_half_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		vh[0] == vh[1] && vh[1] == vh[2])
		else $error("half-vector lanes out of step");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> v_s1)
		else $error("accepted word lost at entry");

endmodule

>>> hw/rtl/bps_unit3.sv
module bps_unit3 #(
	parameter int CW = 21,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][CW-1:0]   in_c,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [2:0][15:0]     out_u,
	output logic [SW-1:0]        out_side
);

	localparam int SQW = 2 * CW;
	localparam int LW  = SQW + 2;
	localparam int XW  = LW + 20;
	localparam int RW  = (XW + 1) / 2;
	localparam int DW  = RW + 1;
	localparam int NW  = CW + 26;
	localparam int QW  = 16;
	localparam int EW  = DW + QW;
	localparam int MW  = 3 * CW + 4 + SW;
	localparam int PW  = SW + 4;

	// magnitudes and squares
	logic [2:0][CW-1:0]  mag_c;
	logic [2:0]          neg_c;
	logic [2:0][SQW-1:0] sq_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = in_c[i][CW-1];
			mag_c[i] = neg_c[i] ? CW'(-in_c[i]) : in_c[i];
			sq_c[i]  = SQW'(mag_c[i]) * SQW'(mag_c[i]);
		end
	end

	logic                v_u1, v_u2;
	logic [2:0][CW-1:0]  mag_u1, mag_u2;
	logic [2:0]          neg_u1, neg_u2;
	logic [2:0][SQW-1:0] sq_u1;
	logic [SW-1:0]       side_u1, side_u2;
	logic [LW-1:0]       len2_u2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_u1 <= 1'b0;
			v_u2 <= 1'b0;
		end else if (en) begin
			v_u1 <= in_valid;
			v_u2 <= v_u1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_u1  <= mag_c;
			neg_u1  <= neg_c;
			sq_u1   <= sq_c;
			side_u1 <= in_side;
			mag_u2  <= mag_u1;
			neg_u2  <= neg_u1;
			side_u2 <= side_u1;
			len2_u2 <= LW'(sq_u1[0]) + LW'(sq_u1[1]) + LW'(sq_u1[2]);
		end
	end

	// square root, one result bit per stage
	logic [XW:0]   srem  [1:RW];
	logic [RW-1:0] sroot [1:RW];
	logic [MW-1:0] smeta [1:RW];
	logic          sval  [1:RW];

	for (genvar gi = 0; gi < RW; gi++) begin : g_sq
		localparam int K = RW - 1 - gi;
		logic [XW:0]   rem_in, trial;
		logic [RW-1:0] root_in;
		logic [MW-1:0] meta_in;
		logic          val_in, take;

		if (gi == 0) begin : g_first
			assign rem_in  = (XW + 1)'({len2_u2, 20'b0});
			assign root_in = '0;
			assign meta_in = {side_u2, (len2_u2 == '0), neg_u2, mag_u2};
			assign val_in  = v_u2;
		end else begin : g_next
			assign rem_in  = srem[gi];
			assign root_in = sroot[gi];
			assign meta_in = smeta[gi];
			assign val_in  = sval[gi];
		end

		assign trial = ((XW + 1)'(root_in) << (K + 1)) + ((XW + 1)'(1) << (2 * K));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sval[gi+1] <= 1'b0;
			end else if (en) begin
				sval[gi+1] <= val_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srem[gi+1]  <= take ? rem_in - trial : rem_in;
				sroot[gi+1] <= take ? (root_in | (RW'(1) << K)) : root_in;
				smeta[gi+1] <= meta_in;
			end
		end
	end

	// divider setup: q = (mag * 2^25 + r) / (2r)
	logic                v_p;
	logic [DW-1:0]       d_p;
	logic [2:0][NW-1:0]  num_p;
	logic [PW-1:0]       meta_p;
	logic [2:0][CW-1:0]  mag_r;

	assign mag_r = smeta[RW][3*CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= sval[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_p    <= {sroot[RW], 1'b0};
			meta_p <= smeta[RW][MW-1:3*CW];
			for (int i = 0; i < 3; i++) begin
				num_p[i] <= (NW'(mag_r[i]) << 25) + NW'(sroot[RW]);
			end
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	logic [2:0][EW-1:0] drem  [1:QW];
	logic [2:0][QW-1:0] dq    [1:QW];
	logic [DW-1:0]      dd    [1:QW];
	logic [PW-1:0]      dmeta [1:QW];
	logic               dval  [1:QW];

	for (genvar gj = 0; gj < QW; gj++) begin : g_div
		localparam int B = QW - 1 - gj;
		logic [2:0][EW-1:0] rem_in, rem_nx;
		logic [2:0][QW-1:0] q_in, q_nx;
		logic [DW-1:0]      d_in;
		logic [PW-1:0]      meta_in;
		logic               val_in;
		logic [EW-1:0]      dsh;

		if (gj == 0) begin : g_first
			for (genvar gl = 0; gl < 3; gl++) begin : g_lane
				assign rem_in[gl] = EW'(num_p[gl]);
			end
			assign q_in    = '0;
			assign d_in    = d_p;
			assign meta_in = meta_p;
			assign val_in  = v_p;
		end else begin : g_next
			assign rem_in  = drem[gj];
			assign q_in    = dq[gj];
			assign d_in    = dd[gj];
			assign meta_in = dmeta[gj];
			assign val_in  = dval[gj];
		end

		assign dsh = EW'(d_in) << B;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_in[l] >= dsh) begin
					rem_nx[l] = rem_in[l] - dsh;
					q_nx[l]   = q_in[l] | (QW'(1) << B);
				end else begin
					rem_nx[l] = rem_in[l];
					q_nx[l]   = q_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dval[gj+1] <= 1'b0;
			end else if (en) begin
				dval[gj+1] <= val_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drem[gj+1]  <= rem_nx;
				dq[gj+1]    <= q_nx;
				dd[gj+1]    <= d_in;
				dmeta[gj+1] <= meta_in;
			end
		end
	end

	// cap at 1.0, apply sign, zero vector gives zero
	logic               v_o;
	logic [2:0][15:0]   u_o;
	logic [SW-1:0]      side_o;
	logic [2:0][15:0]   u_c;
	logic [2:0]         neg_f;
	logic               zero_f;

	assign neg_f  = dmeta[QW][2:0];
	assign zero_f = dmeta[QW][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [15:0] qc;
			qc = (dq[QW][i] > 16'(bps_pkg::ONE_Q14)) ? 16'(bps_pkg::ONE_Q14) : dq[QW][i];
			if (zero_f) begin
				u_c[i] = '0;
			end else begin
				u_c[i] = neg_f[i] ? -qc : qc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= dval[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_o    <= u_c;
			side_o <= dmeta[QW][PW-1:4];
		end
	end

	assign out_valid = v_o;
	assign out_u     = u_o;
	assign out_side  = side_o;

endmodule
